/* rtl/pip_pkg.sv */
`timescale 1ns / 1ps
// Shared types, sizes and command codes for the point-in-polygon crossing unit.
// No dependencies.
package pip_pkg;

    localparam int COORD_W   = 16;
    localparam int MAX_EDGES = 256;
    localparam int ADDR_W    = $clog2(MAX_EDGES);
    localparam int CNT_W     = $clog2(MAX_EDGES + 1);
    localparam int TAG_W     = 16;
    localparam int CROSS_W   = 9;
    localparam int CMD_W     = 2;

    typedef logic signed [COORD_W-1:0]   coord_t;
    typedef logic signed [COORD_W:0]     diff_t;
    typedef logic signed [2*COORD_W+1:0] prod_t;
    typedef logic signed [2*COORD_W+2:0] cross_t;
    typedef logic [CMD_W-1:0]            cmd_t;
    typedef logic [ADDR_W-1:0]           addr_t;
    typedef logic [CNT_W-1:0]            ecount_t;
    typedef logic [CROSS_W-1:0]          xcount_t;
    typedef logic [TAG_W-1:0]            tag_t;

    localparam cmd_t CMD_CLEAR  = CMD_W'(0);
    localparam cmd_t CMD_APPEND = CMD_W'(1);
    localparam cmd_t CMD_QUERY  = CMD_W'(2);

    localparam coord_t RB_RESET = {1'b0, {(COORD_W-1){1'b1}}};

    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
    } seg_t;

    typedef struct packed {
        coord_t qx;
        coord_t qy;
        coord_t rx;
    } query_t;

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } test_stat_t;

    function automatic diff_t coord_sub(coord_t a, coord_t b);
        return diff_t'(a) - diff_t'(b);
    endfunction

endpackage

/* rtl/pip_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command transactions in, query results out.
// Depends on pip_pkg.
interface pip_req_if;
    logic             valid;
    logic             ready;
    pip_pkg::cmd_t    command;
    pip_pkg::coord_t  edge_x1;
    pip_pkg::coord_t  edge_y1;
    pip_pkg::coord_t  edge_x2;
    pip_pkg::coord_t  edge_y2;
    pip_pkg::coord_t  query_x;
    pip_pkg::coord_t  query_y;
    pip_pkg::tag_t    query_tag;

    modport source (output valid, command, edge_x1, edge_y1, edge_x2, edge_y2,
                    query_x, query_y, query_tag, input ready);
    modport sink   (input valid, command, edge_x1, edge_y1, edge_x2, edge_y2,
                    query_x, query_y, query_tag, output ready);
endinterface

interface pip_rsp_if;
    logic              valid;
    logic              ready;
    pip_pkg::tag_t     result_tag;
    logic              inside_res;
    pip_pkg::xcount_t  crossings;
    logic              edges_dropped;

    modport source (output valid, result_tag, inside_res, crossings, edges_dropped,
                    input ready);
    modport sink   (input valid, result_tag, inside_res, crossings, edges_dropped,
                    output ready);
endinterface

/* rtl/pip_edge_ram.sv */
`timescale 1ns / 1ps
// Edge table: one write port, one read port, registered read data.
// Depends on pip_pkg.
module pip_edge_ram (
    input  logic           clk,
    input  logic           we,
    input  pip_pkg::addr_t waddr,
    input  pip_pkg::seg_t  wdata,
    input  logic           re,
    input  pip_pkg::addr_t raddr,
    output pip_pkg::seg_t  rd_data
);

    pip_pkg::seg_t mem [pip_pkg::MAX_EDGES];
    pip_pkg::seg_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/pip_cross_test.sv */
`timescale 1ns / 1ps
// Pipelined segment-crossing test of one stored edge per cycle against the query ray.
// Depends on pip_pkg; fed by pip_edge_ram read data.
module pip_cross_test (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                issue,
    input  pip_pkg::seg_t       seg_rd,
    input  pip_pkg::query_t     qry,
    output pip_pkg::test_stat_t stat
);

    logic v1_reg, v2_reg, v3_reg;

    pip_pkg::diff_t acx_reg, acy_reg, adx_reg, ady_reg, bcx_reg, bdx_reg;
    pip_pkg::prod_t p1_reg, p2_reg, p3_reg, p4_reg;
    logic acy_neg_reg, acy_zero_reg, ady_neg_reg, ady_zero_reg;

    pip_pkg::cross_t c1, c2;
    logic w_zero, s12_ok, s34_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // C = (x1,y1), D = (x2,y2), A = query point, B = (rx, qy)
    always_ff @(posedge clk)
    begin
        acx_reg <= pip_pkg::coord_sub(seg_rd.x1, qry.qx);
        acy_reg <= pip_pkg::coord_sub(seg_rd.y1, qry.qy);
        adx_reg <= pip_pkg::coord_sub(seg_rd.x2, qry.qx);
        ady_reg <= pip_pkg::coord_sub(seg_rd.y2, qry.qy);
        bcx_reg <= pip_pkg::coord_sub(seg_rd.x1, qry.rx);
        bdx_reg <= pip_pkg::coord_sub(seg_rd.x2, qry.rx);

        p1_reg       <= pip_pkg::prod_t'(acx_reg) * pip_pkg::prod_t'(ady_reg);
        p2_reg       <= pip_pkg::prod_t'(adx_reg) * pip_pkg::prod_t'(acy_reg);
        p3_reg       <= pip_pkg::prod_t'(bcx_reg) * pip_pkg::prod_t'(ady_reg);
        p4_reg       <= pip_pkg::prod_t'(bdx_reg) * pip_pkg::prod_t'(acy_reg);
        acy_neg_reg  <= acy_reg[pip_pkg::COORD_W];
        acy_zero_reg <= (acy_reg == '0);
        ady_neg_reg  <= ady_reg[pip_pkg::COORD_W];
        ady_zero_reg <= (ady_reg == '0);
    end

    // A and B share y, so cross(AC,BC) and cross(AD,BD) reduce to dy * (rx - qx).
    always_comb
    begin
        c1     = pip_pkg::cross_t'(p1_reg) - pip_pkg::cross_t'(p2_reg);
        c2     = pip_pkg::cross_t'(p3_reg) - pip_pkg::cross_t'(p4_reg);
        w_zero = (qry.rx == qry.qx);
        s12_ok = (c1 == '0) || (c2 == '0)
                 || (c1[2*pip_pkg::COORD_W+2] != c2[2*pip_pkg::COORD_W+2]);
        s34_ok = w_zero || acy_zero_reg || ady_zero_reg || (acy_neg_reg != ady_neg_reg);
    end

    assign stat.busy      = v1_reg | v2_reg | v3_reg;
    assign stat.hit_valid = v3_reg;
    assign stat.hit       = s12_ok & s34_ok;

endmodule

/* rtl/point_in_polygon_ray_crossing_unit.sv */
`timescale 1ns / 1ps
// Point-in-polygon classifier by ray crossing count, top level.
// Depends on pip_pkg, pip_if, pip_edge_ram, pip_cross_test.
//
// req carries command transactions: clear, append edge, or query point.
// rsp returns one transaction per query: tag, inside bit, crossing count and
// the sticky dropped-edge flag. cfg_we/cfg_wdata write right_bound, the x where
// each query ray ends; write it only while the unit is idle.
//
// Clear and append complete in the cycle they are accepted; the unit accepts
// the next transaction in the following cycle. An append to a full table is
// dropped and sets the dropped flag until the next clear.
// A query walks the stored edges at one edge per cycle through the edge RAM
// read port and the crossing-test pipeline, waits for the pipeline to drain
// and then registers its result; the unit returns to idle at that same edge.
// req stays low during that walk.
// The result sits in an output register; while rsp is stalled, clears and
// appends are still accepted, and a following query runs but holds its result
// until the register frees up.
// Reset empties the table, clears the dropped flag and sets right_bound to 32767.
module point_in_polygon_ray_crossing_unit (
    input  logic             clk,
    input  logic             rst_n,
    pip_req_if.sink          req,
    pip_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  pip_pkg::coord_t  cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    pip_pkg::ecount_t    edge_count_reg, edge_count_next;
    logic                ovf_reg, ovf_next;
    pip_pkg::coord_t     rb_reg, rb_next;
    pip_pkg::query_t     qry_reg, qry_next;
    pip_pkg::tag_t       tag_reg, tag_next;
    pip_pkg::ecount_t    idx_reg, idx_next;
    pip_pkg::xcount_t    count_reg, count_next;
    logic                parity_reg, parity_next;
    logic                out_valid_reg, out_valid_next;
    pip_pkg::tag_t       res_tag_reg, res_tag_next;
    logic                res_inside_reg, res_inside_next;
    pip_pkg::xcount_t    res_cross_reg, res_cross_next;
    logic                res_drop_reg, res_drop_next;

    logic                accept, full, ram_we, rd_en, load;
    pip_pkg::seg_t       wr_seg, rd_seg;
    pip_pkg::test_stat_t stat;

    assign accept = req.valid && req.ready;
    assign full   = (edge_count_reg == pip_pkg::CNT_W'(pip_pkg::MAX_EDGES));

    assign wr_seg.x1 = req.edge_x1;
    assign wr_seg.y1 = req.edge_y1;
    assign wr_seg.x2 = req.edge_x2;
    assign wr_seg.y2 = req.edge_y2;

    pip_edge_ram u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (edge_count_reg[pip_pkg::ADDR_W-1:0]),
        .wdata   (wr_seg),
        .re      (rd_en),
        .raddr   (idx_reg[pip_pkg::ADDR_W-1:0]),
        .rd_data (rd_seg)
    );

    pip_cross_test u_test (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (rd_en),
        .seg_rd (rd_seg),
        .qry    (qry_reg),
        .stat   (stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        ovf_next        = ovf_reg;
        rb_next         = cfg_we ? cfg_wdata : rb_reg;
        qry_next        = qry_reg;
        tag_next        = tag_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        parity_next     = parity_reg;
        res_tag_next    = res_tag_reg;
        res_inside_next = res_inside_reg;
        res_cross_next  = res_cross_reg;
        res_drop_next   = res_drop_reg;
        ram_we          = 1'b0;
        rd_en           = 1'b0;
        load            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.command)
                        pip_pkg::CMD_CLEAR:
                        begin
                            edge_count_next = '0;
                            ovf_next        = 1'b0;
                        end
                        pip_pkg::CMD_APPEND:
                        begin
                            if (full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                edge_count_next = edge_count_reg + 1'b1;
                            end
                        end
                        pip_pkg::CMD_QUERY:
                        begin
                            qry_next.qx = req.query_x;
                            qry_next.qy = req.query_y;
                            qry_next.rx = rb_reg;
                            tag_next    = req.query_tag;
                            idx_next    = '0;
                            count_next  = '0;
                            parity_next = 1'b0;
                            state_next  = ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (idx_reg < edge_count_reg)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (stat.hit_valid && stat.hit)
        begin
            parity_next = ~parity_reg;
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        if (load)
        begin
            out_valid_next  = 1'b1;
            res_tag_next    = tag_reg;
            res_inside_next = parity_reg;
            res_cross_next  = count_reg;
            res_drop_next   = ovf_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            edge_count_reg <= '0;
            ovf_reg        <= 1'b0;
            rb_reg         <= pip_pkg::RB_RESET;
            qry_reg        <= '0;
            tag_reg        <= '0;
            idx_reg        <= '0;
            count_reg      <= '0;
            parity_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_tag_reg    <= '0;
            res_inside_reg <= 1'b0;
            res_cross_reg  <= '0;
            res_drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            ovf_reg        <= ovf_next;
            rb_reg         <= rb_next;
            qry_reg        <= qry_next;
            tag_reg        <= tag_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            parity_reg     <= parity_next;
            out_valid_reg  <= out_valid_next;
            res_tag_reg    <= res_tag_next;
            res_inside_reg <= res_inside_next;
            res_cross_reg  <= res_cross_next;
            res_drop_reg   <= res_drop_next;
        end
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.result_tag    = res_tag_reg;
    assign rsp.inside_res    = res_inside_reg;
    assign rsp.crossings     = res_cross_reg;
    assign rsp.edges_dropped = res_drop_reg;

    a_no_write_during_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !ram_we)
        else $error("edge table written while a query walks it");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (idx_reg < edge_count_reg))
        else $error("edge read beyond the stored count");

    a_hit_only_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        stat.hit_valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("crossing test result outside a query");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (int'(count_reg) <= int'(idx_reg)))
        else $error("crossing count exceeds edges issued");

    a_table_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(edge_count_reg) <= pip_pkg::MAX_EDGES)
        else $error("edge count beyond table depth");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for point_in_polygon_ray_crossing_unit: directed and random command
// transactions with random idling on both channels, each query result checked.
// Depends on pip_pkg, pip_if and the unit RTL.
module tb;

    localparam pip_pkg::cmd_t CMD_UNUSED = 2'd3;
    localparam int   IDLE_LIMIT = 5000;
    localparam int   MAX_IDLE   = 11;
    localparam int   CMIN       = -32768;
    localparam int   CMAX       = 32767;

    typedef struct packed {
        pip_pkg::cmd_t   command;
        pip_pkg::coord_t ex1, ey1, ex2, ey2;
        pip_pkg::coord_t qx, qy;
        pip_pkg::tag_t   tag;
    } pip_txn_t;

    typedef struct {
        pip_pkg::tag_t    tag;
        logic             inside_bit;
        pip_pkg::xcount_t crossings;
        logic             dropped;
    } pip_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pip_req_if req_ch();
    pip_rsp_if rsp_ch();

    logic            drv_valid = 1'b0;
    pip_txn_t        drv_txn   = '0;
    logic            rsp_ready = 1'b0;
    logic            cfg_we    = 1'b0;
    pip_pkg::coord_t cfg_wdata = '0;

    assign req_ch.valid     = drv_valid;
    assign req_ch.command   = drv_txn.command;
    assign req_ch.edge_x1   = drv_txn.ex1;
    assign req_ch.edge_y1   = drv_txn.ey1;
    assign req_ch.edge_x2   = drv_txn.ex2;
    assign req_ch.edge_y2   = drv_txn.ey2;
    assign req_ch.query_x   = drv_txn.qx;
    assign req_ch.query_y   = drv_txn.qy;
    assign req_ch.query_tag = drv_txn.tag;
    assign rsp_ch.ready     = rsp_ready;

    point_in_polygon_ray_crossing_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predicted unit state
    pip_pkg::seg_t   edge_tbl [pip_pkg::MAX_EDGES];
    int unsigned     edge_cnt  = 0;
    bit              drop_flag = 1'b0;
    pip_pkg::coord_t ray_end   = pip_pkg::RB_RESET;

    pip_result_t expected_results [$];
    pip_txn_t    pending_txns [$];
    int          error_count   = 0;
    int          items_queued  = 0;
    int          idle_cycles   = 0;
    int          drv_gap       = 0;
    int          rsp_stall     = 0;
    int          drv_max_gap   = MAX_IDLE;
    int          rsp_max_stall = MAX_IDLE;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int draw_idle(int max_gap);
        return int'($urandom_range(0, max_gap));
    endfunction

    function automatic int cross_sign(longint ux, longint uy, longint vx, longint vy);
        longint c;
        c = ux * vy - vx * uy;
        return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
    endfunction

    // segment (ax,ay)-(bx,ay) against stored edge, touching and collinear count
    function automatic bit ray_meets_edge(longint ax, longint ay, longint bx,
                                          pip_pkg::seg_t e);
        longint cx, cy, dx, dy;
        int     s1, s2, s3, s4;
        cx = e.x1;
        cy = e.y1;
        dx = e.x2;
        dy = e.y2;
        s1 = cross_sign(cx - ax, cy - ay, dx - ax, dy - ay);
        s2 = cross_sign(cx - bx, cy - ay, dx - bx, dy - ay);
        s3 = cross_sign(cx - ax, cy - ay, cx - bx, cy - ay);
        s4 = cross_sign(dx - ax, dy - ay, dx - bx, dy - ay);
        return (s1 * s2 <= 0) && (s3 * s4 <= 0);
    endfunction

    task automatic predict_txn(input pip_txn_t t);
        int unsigned hits;
        pip_result_t r;
        hits = 0;
        case (t.command)
            pip_pkg::CMD_CLEAR:
            begin
                edge_cnt  = 0;
                drop_flag = 1'b0;
            end
            pip_pkg::CMD_APPEND:
            begin
                if (edge_cnt >= pip_pkg::MAX_EDGES)
                    drop_flag = 1'b1;
                else
                begin
                    edge_tbl[edge_cnt] = '{x1: t.ex1, y1: t.ey1, x2: t.ex2, y2: t.ey2};
                    edge_cnt++;
                end
            end
            pip_pkg::CMD_QUERY:
            begin
                for (int i = 0; i < edge_cnt; i++)
                    if (ray_meets_edge(t.qx, t.qy, ray_end, edge_tbl[i]))
                        hits++;
                r.tag        = t.tag;
                r.inside_bit = hits[0];
                r.crossings  = (hits > 511) ? pip_pkg::xcount_t'(511)
                                            : pip_pkg::xcount_t'(hits);
                r.dropped    = drop_flag;
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            drv_valid <= 1'b0;
        else if (!drv_valid || req_ch.ready)
        begin
            if (drv_gap > 0)
            begin
                drv_valid <= 1'b0;
                drv_gap   <= drv_gap - 1;
            end
            else if (pending_txns.size() != 0)
            begin
                drv_txn   <= pending_txns.pop_front();
                drv_valid <= 1'b1;
                drv_gap   <= draw_idle(drv_max_gap);
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // result sink stalls
    always @(posedge clk)
    begin
        int n;
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (rsp_ch.valid && rsp_ready)
        begin
            n = draw_idle(rsp_max_stall);
            if (n == 0)
                rsp_ready <= 1'b1;
            else
            begin
                rsp_ready <= 1'b0;
                rsp_stall <= n - 1;
            end
        end
        else if (rsp_stall > 0)
        begin
            rsp_ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
        end
        else
            rsp_ready <= 1'b1;
    end

    // monitor: predict on accepted commands, check accepted results, watchdog
    always @(posedge clk)
    begin
        pip_result_t want;
        if (rst_n)
        begin
            if (drv_valid && req_ch.ready)
                predict_txn(drv_txn);
            if (rsp_ch.valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result transaction with none expected, tag %0h",
                             $time, rsp_ch.result_tag);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.result_tag !== want.tag)
                        report_mismatch("result_tag", 32'(want.tag),
                                        32'(rsp_ch.result_tag));
                    if (rsp_ch.inside_res !== want.inside_bit)
                        report_mismatch("inside_res", 32'(want.inside_bit),
                                        32'(rsp_ch.inside_res));
                    if (rsp_ch.crossings !== want.crossings)
                        report_mismatch("crossings", 32'(want.crossings),
                                        32'(rsp_ch.crossings));
                    if (rsp_ch.edges_dropped !== want.dropped)
                        report_mismatch("edges_dropped", 32'(want.dropped),
                                        32'(rsp_ch.edges_dropped));
                end
            end
            if ((drv_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[point_in_polygon_ray_crossing_unit] ERROR");
                $finish;
            end
        end
    end

    function automatic pip_pkg::coord_t rand_coord();
        return pip_pkg::coord_t'($urandom);
    endfunction

    function automatic pip_pkg::coord_t clamp_coord(int v);
        if (v > CMAX)
            return pip_pkg::coord_t'(CMAX);
        if (v < CMIN)
            return pip_pkg::coord_t'(CMIN);
        return pip_pkg::coord_t'(v);
    endfunction

    task automatic queue_txn(input pip_pkg::cmd_t c,
                             input pip_pkg::coord_t x1, y1, x2, y2, qx, qy,
                             input pip_pkg::tag_t tag);
        pip_txn_t t;
        t = '{c, x1, y1, x2, y2, qx, qy, tag};
        pending_txns.push_back(t);
        items_queued++;
    endtask

    task automatic queue_append(input pip_pkg::coord_t x1, y1, x2, y2);
        queue_txn(pip_pkg::CMD_APPEND, x1, y1, x2, y2, rand_coord(), rand_coord(),
                  pip_pkg::tag_t'($urandom));
    endtask

    task automatic queue_query(input pip_pkg::coord_t qx, qy, input pip_pkg::tag_t tag);
        queue_txn(pip_pkg::CMD_QUERY, rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), qx, qy, tag);
    endtask

    task automatic queue_other(input pip_pkg::cmd_t c);
        queue_txn(c, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), pip_pkg::tag_t'($urandom));
    endtask

    // closed polygon with random vertices, then queries around it
    task automatic queue_polygon_run();
        pip_pkg::coord_t vx [12];
        pip_pkg::coord_t vy [12];
        int     n, cx, cy, span, k;
        n  = $urandom_range(3, 12);
        cx = int'(rand_coord());
        cy = int'(rand_coord());
        case ($urandom_range(0, 3))
            0:       span = 20;
            1:       span = 2000;
            2:       span = 40000;
            default: span = 200;
        endcase
        if ($urandom_range(0, 3) != 0)
            queue_other(pip_pkg::CMD_CLEAR);
        for (int i = 0; i < n; i++)
        begin
            vx[i] = clamp_coord(cx + int'($urandom_range(0, 2 * span)) - span);
            vy[i] = clamp_coord(cy + int'($urandom_range(0, 2 * span)) - span);
        end
        for (int i = 0; i < n; i++)
            queue_append(vx[i], vy[i], vx[(i + 1) % n], vy[(i + 1) % n]);
        for (int j = $urandom_range(2, 8); j > 0; j--)
        begin
            k = $urandom_range(0, n - 1);
            case ($urandom_range(0, 4))
                0: queue_query(vx[k], vy[k], pip_pkg::tag_t'($urandom));
                1: queue_query(clamp_coord(cx + int'($urandom_range(0, 2 * span)) - span),
                               vy[k], pip_pkg::tag_t'($urandom));
                2: queue_query(ray_end, vy[k], pip_pkg::tag_t'($urandom));
                default:
                    queue_query(clamp_coord(cx + int'($urandom_range(0, 2 * span)) - span),
                                clamp_coord(cy + int'($urandom_range(0, 2 * span)) - span),
                                pip_pkg::tag_t'($urandom));
            endcase
        end
    endtask

    task automatic run_random_phase(int n_items);
        int stop_at;
        stop_at = items_queued + n_items;
        while (items_queued < stop_at)
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: queue_polygon_run();
                7: queue_append(rand_coord(), rand_coord(), rand_coord(), rand_coord());
                8: queue_query(rand_coord(), rand_coord(), pip_pkg::tag_t'($urandom));
                default: queue_other($urandom_range(0, 1) ? CMD_UNUSED : pip_pkg::CMD_CLEAR);
            endcase
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_txns.size() != 0 || drv_valid || expected_results.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_ray_end(input pip_pkg::coord_t v);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ray_end   = v;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, right bound at reset value
        queue_query(16'sd0, 16'sd0, 16'h0000);
        queue_other(CMD_UNUSED);
        queue_other(pip_pkg::CMD_CLEAR);
        queue_append(-16'sd100, -16'sd100, 16'sd100, -16'sd100);
        queue_append(16'sd100, -16'sd100, 16'sd0, 16'sd100);
        queue_append(16'sd0, 16'sd100, -16'sd100, -16'sd100);
        queue_query(16'sd0, 16'sd0, 16'hffff);
        queue_query(16'sd200, 16'sd0, 16'h5a5a);
        queue_query(16'sd0, -16'sd100, 16'ha5a5);
        queue_query(16'sd0, 16'sd100, 16'h0001);
        queue_append(16'sd5, 16'sd5, 16'sd5, 16'sd5);
        queue_query(16'sd0, 16'sd5, 16'h8000);
        queue_append(pip_pkg::coord_t'(CMIN), pip_pkg::coord_t'(CMIN),
                     pip_pkg::coord_t'(CMAX), pip_pkg::coord_t'(CMAX));
        queue_append(pip_pkg::coord_t'(CMAX), pip_pkg::coord_t'(CMIN),
                     pip_pkg::coord_t'(CMIN), pip_pkg::coord_t'(CMAX));
        queue_query(pip_pkg::coord_t'(CMIN), 16'sd0, 16'h7fff);
        queue_query(pip_pkg::coord_t'(CMAX), pip_pkg::coord_t'(CMAX), 16'h00ff);
        queue_query(pip_pkg::coord_t'(CMAX), pip_pkg::coord_t'(CMIN), 16'hff00);
        queue_query(pip_pkg::coord_t'(CMIN), pip_pkg::coord_t'(CMIN), 16'h1234);
        queue_other(pip_pkg::CMD_CLEAR);
        queue_query(16'sd0, 16'sd0, 16'hfedc);
        queue_txn(CMD_UNUSED, pip_pkg::coord_t'(CMAX), pip_pkg::coord_t'(CMIN),
                  pip_pkg::coord_t'(CMAX), pip_pkg::coord_t'(CMIN),
                  pip_pkg::coord_t'(CMAX), pip_pkg::coord_t'(CMIN), 16'hffff);

        write_ray_end(pip_pkg::coord_t'(CMIN));
        run_random_phase(20);

        // full table: back-to-back appends past the limit, then clear
        write_ray_end(16'sd0);
        drv_max_gap   = 0;
        rsp_max_stall = 0;
        queue_other(pip_pkg::CMD_CLEAR);
        for (int i = 0; i < pip_pkg::MAX_EDGES; i++)
            if (i % 2 == 0)
                queue_append(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            else
                queue_append(clamp_coord(int'($urandom_range(0, 200)) - 100),
                             clamp_coord(int'($urandom_range(0, 200)) - 100),
                             clamp_coord(int'($urandom_range(0, 200)) - 100),
                             clamp_coord(int'($urandom_range(0, 200)) - 100));
        queue_query(-16'sd50, 16'sd0, pip_pkg::tag_t'($urandom));
        for (int i = 0; i < 4; i++)
            queue_append(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        for (int i = 0; i < 6; i++)
            queue_query(clamp_coord(int'($urandom_range(0, 300)) - 150),
                        clamp_coord(int'($urandom_range(0, 300)) - 150),
                        pip_pkg::tag_t'($urandom));
        queue_other(pip_pkg::CMD_CLEAR);
        queue_query(16'sd0, 16'sd0, pip_pkg::tag_t'($urandom));

        write_ray_end(rand_coord());
        drv_max_gap   = 0;
        rsp_max_stall = MAX_IDLE;
        run_random_phase(20);

        write_ray_end(rand_coord());
        drv_max_gap   = MAX_IDLE;
        rsp_max_stall = 0;
        run_random_phase(20);

        write_ray_end(pip_pkg::coord_t'(CMAX));
        drv_max_gap   = MAX_IDLE;
        rsp_max_stall = MAX_IDLE;
        run_random_phase(30);

        wait_drained();
        repeat (300) @(negedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("[point_in_polygon_ray_crossing_unit] OK");
        else
            $display("[point_in_polygon_ray_crossing_unit] ERROR");
        $finish;
    end

endmodule
